/* rtl/ggi_pkg.sv */
// ----------------------------------------------------------------------------
// ggi_pkg
// Shared widths, codes and types of the gaussian grid interpolator.
// ----------------------------------------------------------------------------
package ggi_pkg;

    localparam int DEF_GRID_SIDE = 256;
    localparam int DEF_MAX_TAPS  = 15;

    localparam int SAMPLE_W  = 24;
    localparam int WT_W      = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 64;
    localparam int COORD_W   = 16;
    localparam int VAL_W     = 18;
    localparam int MAG_W     = 17;
    localparam int TAP_CNT_W = 4;
    localparam int HW_W      = 3;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // input item codes
    localparam logic [1:0] MODE_GRID = 2'd0;
    localparam logic [1:0] MODE_SQW  = 2'd1;
    localparam logic [1:0] MODE_PF   = 2'd2;
    localparam logic [1:0] MODE_EVAL = 2'd3;

    // register indexes, byte address 4*index
    localparam logic [1:0] REG_GRID_SIDE  = 2'd0;
    localparam logic [1:0] REG_HALF_WIDTH = 2'd1;
    localparam logic [1:0] REG_COMPLEX    = 2'd2;

    localparam logic [8:0] RST_GRID_SIDE  = 9'd256;
    localparam logic [2:0] RST_HALF_WIDTH = 3'd3;
    localparam logic       RST_COMPLEX    = 1'b1;

    typedef struct packed {
        logic grid_we;
        logic sw_we;
        logic pf_we;
        logic grid_re;
        logic wt_re;
    } ggi_store_ctl_t;

    function automatic int ggi_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* rtl/ggi_mul_unit.sv */
// ----------------------------------------------------------------------------
// ggi_mul_unit
// Shared 33x33 multiplier with registered product and a registered
// Q8.24 round-and-saturate stage behind it.
// ----------------------------------------------------------------------------
module ggi_mul_unit
    import ggi_pkg::*;
(
    input  logic                     clk,
    input  logic [WT_W-1:0]          op_a,
    input  logic signed [WT_W:0]     op_b,
    output logic [PROD_W-1:0]        prod,
    output logic [WT_W-1:0]          rnd,
    output logic                     rnd_sat
);

    logic signed [2*WT_W+1:0] full;
    logic [PROD_W-1:0]        prod_reg;
    logic [WT_W-1:0]          rnd_reg;
    logic                     rnd_sat_reg;
    logic [WT_W+8:0]          rsum;

    assign full = $signed({1'b0, op_a}) * op_b;

    // (p + 2^23) >> 24 as the upper bits plus the rounding bit
    assign rsum = {1'b0, prod_reg[PROD_W-1:24]} + (WT_W+9)'(prod_reg[23]);

    always_ff @(posedge clk)
    begin
        prod_reg    <= full[PROD_W-1:0];
        rnd_sat_reg <= |rsum[WT_W+8:WT_W];
        rnd_reg     <= (|rsum[WT_W+8:WT_W]) ? '1 : rsum[WT_W-1:0];
    end

    assign prod    = prod_reg;
    assign rnd     = rnd_reg;
    assign rnd_sat = rnd_sat_reg;

endmodule

/* rtl/ggi_mod_unit.sv */
// ----------------------------------------------------------------------------
// ggi_mod_unit
// Bit-serial restoring remainder of a signed coordinate by the grid side,
// one quotient bit per cycle, result folded into [0, side).
// ----------------------------------------------------------------------------
module ggi_mod_unit
    import ggi_pkg::*;
#(
    parameter int SIDE_W = 9
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  mag,
    input  logic              neg,
    input  logic [SIDE_W-1:0] side,
    output logic              done,
    output logic [SIDE_W-1:0] result
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [SIDE_W-1:0] r_reg, r_next;
    logic [SIDE_W:0]   partial;

    assign partial = {r_reg, mag_reg[MAG_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            mag_next  = mag;
            neg_next  = neg;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (partial >= {1'b0, side})
                r_next = SIDE_W'(partial - {1'b0, side});
            else
                r_next = partial[SIDE_W-1:0];
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        r_reg   <= r_next;
    end

    // truncating remainder of a negative value folds up by one side
    assign done   = done_reg;
    assign result = (neg_reg && r_reg != '0) ? side - r_reg : r_reg;

endmodule

/* rtl/ggi_store.sv */
// ----------------------------------------------------------------------------
// ggi_store
// Grid sample memories and the square-weight and point-factor tables,
// one write port and one registered read port each.
// ----------------------------------------------------------------------------
module ggi_store
    import ggi_pkg::*;
#(
    parameter int  GRID_SIDE = DEF_GRID_SIDE,
    parameter int  MAX_TAPS  = DEF_MAX_TAPS,
    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE,
    localparam int GRID_AW    = $clog2(GRID_DEPTH),
    localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int PF_W       = $clog2(2 * MAX_TAPS)
)(
    input  logic                       clk,
    input  ggi_store_ctl_t             ctl,
    input  logic [GRID_AW-1:0]         wr_grid_addr,
    input  logic signed [SAMPLE_W-1:0] wr_re,
    input  logic signed [SAMPLE_W-1:0] wr_im,
    input  logic [TAP_W-1:0]           wr_sw_addr,
    input  logic [PF_W-1:0]            wr_pf_addr,
    input  logic [WT_W-1:0]            wr_weight,
    input  logic [GRID_AW-1:0]         rd_grid_addr,
    input  logic [TAP_W-1:0]           rd_sw_addr,
    input  logic [PF_W-1:0]            rd_pf_addr,
    output logic signed [SAMPLE_W-1:0] grid_re_q,
    output logic signed [SAMPLE_W-1:0] grid_im_q,
    output logic [WT_W-1:0]            sw_q,
    output logic [WT_W-1:0]            pf_q
);

    logic signed [SAMPLE_W-1:0] grid_re_mem [GRID_DEPTH];
    logic signed [SAMPLE_W-1:0] grid_im_mem [GRID_DEPTH];
    logic [WT_W-1:0]            sw_mem [MAX_TAPS];
    logic [WT_W-1:0]            pf_mem [2*MAX_TAPS];

    logic signed [SAMPLE_W-1:0] grid_re_q_reg;
    logic signed [SAMPLE_W-1:0] grid_im_q_reg;
    logic [WT_W-1:0]            sw_q_reg;
    logic [WT_W-1:0]            pf_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.grid_we)
        begin
            grid_re_mem[wr_grid_addr] <= wr_re;
            grid_im_mem[wr_grid_addr] <= wr_im;
        end
        if (ctl.grid_re)
        begin
            grid_re_q_reg <= grid_re_mem[rd_grid_addr];
            grid_im_q_reg <= grid_im_mem[rd_grid_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sw_we)
            sw_mem[wr_sw_addr] <= wr_weight;
        if (ctl.pf_we)
            pf_mem[wr_pf_addr] <= wr_weight;
        if (ctl.wt_re)
        begin
            sw_q_reg <= sw_mem[rd_sw_addr];
            pf_q_reg <= pf_mem[rd_pf_addr];
        end
    end

    assign grid_re_q = grid_re_q_reg;
    assign grid_im_q = grid_im_q_reg;
    assign sw_q      = sw_q_reg;
    assign pf_q      = pf_q_reg;

endmodule

/* rtl/gaussian_grid_interpolator_core.sv */
// ----------------------------------------------------------------------------
// gaussian_grid_interpolator_core
// Grid, weight and factor writes do not hold the input side; the next item
// is taken in the cycle after. An evaluation holds the input side until its
// result is offered: two coordinate wraps, one after the other, then the
// tap pairs in turn, each read and weighted on the one shared multiplier.
// Reset restores the register defaults and clears control state only;
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
module gaussian_grid_interpolator_core
    import ggi_pkg::*;
#(
    parameter int GRID_SIDE = DEF_GRID_SIDE,
    parameter int MAX_TAPS  = DEF_MAX_TAPS
)(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic [15:0]                grid_address,
    input  logic signed [SAMPLE_W-1:0] sample_re,
    input  logic signed [SAMPLE_W-1:0] sample_im,
    input  logic [TAP_CNT_W-1:0]       tap_index,
    input  logic                       axis,
    input  logic [WT_W-1:0]            weight,
    input  logic signed [COORD_W-1:0]  coord_first,
    input  logic signed [COORD_W-1:0]  coord_second,
    input  logic [WT_W-1:0]            amplitude,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [ACC_W-1:0]    sum_re,
    output logic signed [ACC_W-1:0]    sum_im,
    output logic                       saturated
);

    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int SIDE_W     = $clog2(GRID_SIDE + 1);
    localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PF_W       = $clog2(2 * MAX_TAPS);
    localparam int HW_MAX     = (MAX_TAPS - 1) / 2;
    localparam int GA_X_W     = ggi_max(GRID_AW, 16);
    localparam int SIDE_X_W   = ggi_max(SIDE_W, 9);
    localparam int TAP_X_W    = ggi_max(PF_W, 5);

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_COL   = 16'b0000_0000_0000_0010,
        S_COLW  = 16'b0000_0000_0000_0100,
        S_ROWW  = 16'b0000_0000_0000_1000,
        S_RD1   = 16'b0000_0000_0001_0000,
        S_RD2   = 16'b0000_0000_0010_0000,
        S_MW1   = 16'b0000_0000_0100_0000,
        S_MW2   = 16'b0000_0000_1000_0000,
        S_MAMP  = 16'b0000_0001_0000_0000,
        S_MT2   = 16'b0000_0010_0000_0000,
        S_MU    = 16'b0000_0100_0000_0000,
        S_MWAIT = 16'b0000_1000_0000_0000,
        S_MQ    = 16'b0001_0000_0000_0000,
        S_MIM   = 16'b0010_0000_0000_0000,
        S_ACCIM = 16'b0100_0000_0000_0000,
        S_DONE  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]              grid_side_reg;
    logic [HW_W-1:0]         half_width_reg;
    logic                    complex_reg;

    logic [TAP_CNT_W-1:0]    t1_reg, t1_next;
    logic [TAP_CNT_W-1:0]    t2_reg, t2_next;
    logic [SIDE_W-1:0]       col_cur_reg, col_cur_next;
    logic [SIDE_W-1:0]       row0_reg, row0_next;
    logic [SIDE_W-1:0]       row_cur_reg, row_cur_next;
    logic [COORD_W-1:0]      coord_first_reg, coord_first_next;
    logic [COORD_W-1:0]      coord_second_reg, coord_second_next;
    logic [WT_W-1:0]         amp_reg, amp_next;
    logic [WT_W-1:0]         sw1_reg, sw1_next;
    logic [WT_W-1:0]         pf1_reg, pf1_next;
    logic [WT_W-1:0]         t2v_reg, t2v_next;
    logic [WT_W-1:0]         qv_reg, qv_next;
    logic [ACC_W-1:0]        acc_re_reg, acc_re_next;
    logic [ACC_W-1:0]        acc_im_reg, acc_im_next;
    logic                    sat_reg, sat_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]        sum_re_reg, sum_re_next;
    logic [ACC_W-1:0]        sum_im_reg, sum_im_next;
    logic                    saturated_reg, saturated_next;

    logic                    in_acc;
    logic                    cfg_wr;
    logic [HW_W-1:0]         hw_eff;
    logic [TAP_CNT_W-1:0]    span;
    logic [SIDE_X_W-1:0]     gs_x;
    logic [SIDE_W-1:0]       side_eff;

    logic                    mod_start;
    logic                    mod_sel_row;
    logic [COORD_W-1:0]      mod_coord;
    logic [VAL_W-1:0]        mod_val;
    logic [VAL_W-1:0]        mod_abs;
    logic                    mod_done;
    logic [SIDE_W-1:0]       mod_result;

    logic [WT_W-1:0]         mul_a;
    logic signed [WT_W:0]    mul_b;
    logic [PROD_W-1:0]       prod;
    logic [WT_W-1:0]         rnd;
    logic                    rnd_sat;

    ggi_store_ctl_t          store_ctl;
    logic [GA_X_W-1:0]       ga_x;
    logic                    grid_in_range;
    logic                    tap_ok;
    logic [TAP_X_W-1:0]      tap_x;
    logic [TAP_X_W-1:0]      pf_wr_x;
    logic [TAP_X_W-1:0]      t1_x;
    logic [TAP_X_W-1:0]      t2_x;
    logic [TAP_X_W-1:0]      pf_t2_x;
    logic [TAP_W-1:0]        sw_raddr;
    logic [PF_W-1:0]         pf_raddr;
    logic [GRID_AW-1:0]      grid_raddr;
    logic signed [SAMPLE_W-1:0] grid_re_q;
    logic signed [SAMPLE_W-1:0] grid_im_q;
    logic [WT_W-1:0]         sw_q;
    logic [WT_W-1:0]         pf_q;

    logic [ACC_W:0]          acc_re_add;
    logic [ACC_W:0]          acc_im_add;

    // add floor((p + 2^15) / 2^16) to the sum, clamp to the 48-bit range
    function automatic logic [ACC_W:0] acc_add(input logic [ACC_W-1:0] acc,
                                               input logic [PROD_W-1:0] p);
        logic [ACC_W:0] s;
        logic           ovf;
        s   = {acc[ACC_W-1], acc} + {p[PROD_W-1], p[PROD_W-1:PROD_W-ACC_W]}
            + (ACC_W+1)'(p[PROD_W-ACC_W-1]);
        ovf = s[ACC_W] ^ s[ACC_W-1];
        if (!ovf)
            return {1'b0, s[ACC_W-1:0]};
        else if (s[ACC_W])
            return {1'b1, 1'b1, {(ACC_W-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg  <= RST_GRID_SIDE;
            half_width_reg <= RST_HALF_WIDTH;
            complex_reg    <= RST_COMPLEX;
        end
        else if (cfg_wr)
        begin
            case (paddr[PADDR_W-1:2])
                REG_GRID_SIDE:  grid_side_reg  <= pwdata[8:0];
                REG_HALF_WIDTH: half_width_reg <= pwdata[HW_W-1:0];
                REG_COMPLEX:    complex_reg    <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1:2])
            REG_GRID_SIDE:  prdata = {23'b0, grid_side_reg};
            REG_HALF_WIDTH: prdata = {29'b0, half_width_reg};
            REG_COMPLEX:    prdata = {31'b0, complex_reg};
            default:        prdata = '0;
        endcase
    end

    // effective side and half width after clamping
    assign gs_x = SIDE_X_W'(grid_side_reg);

    always_comb
    begin
        if (grid_side_reg == '0)
            side_eff = SIDE_W'(1);
        else if (int'(grid_side_reg) > GRID_SIDE)
            side_eff = SIDE_W'(GRID_SIDE);
        else
            side_eff = gs_x[SIDE_W-1:0];
    end

    assign hw_eff = (int'(half_width_reg) > HW_MAX) ? HW_W'(HW_MAX) : half_width_reg;
    assign span   = {hw_eff, 1'b0};

    // ------------------------------------------------------------------------
    // input handshake and store writes
    // ------------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign ga_x          = GA_X_W'(grid_address);
    assign grid_in_range = ({16'b0, grid_address} < 32'(GRID_DEPTH));
    assign tap_ok        = (int'(tap_index) < MAX_TAPS);
    assign tap_x         = TAP_X_W'(tap_index);
    assign pf_wr_x       = tap_x + (axis ? TAP_X_W'(MAX_TAPS) : '0);

    assign t1_x    = TAP_X_W'(t1_reg);
    assign t2_x    = TAP_X_W'(t2_reg);
    assign pf_t2_x = t2_x + TAP_X_W'(MAX_TAPS);

    assign sw_raddr   = (state_reg == S_RD1) ? t1_x[TAP_W-1:0] : t2_x[TAP_W-1:0];
    assign pf_raddr   = (state_reg == S_RD1) ? t1_x[PF_W-1:0] : pf_t2_x[PF_W-1:0];
    // product holds row*side here
    assign grid_raddr = prod[GRID_AW-1:0] + GRID_AW'(col_cur_reg);

    always_comb
    begin
        store_ctl.grid_we = in_acc && (mode == MODE_GRID) && grid_in_range;
        store_ctl.sw_we   = in_acc && (mode == MODE_SQW) && tap_ok;
        store_ctl.pf_we   = in_acc && (mode == MODE_PF) && tap_ok;
        store_ctl.grid_re = (state_reg == S_RD2);
        store_ctl.wt_re   = (state_reg == S_RD1) || (state_reg == S_RD2);
    end

    ggi_store #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_TAPS  (MAX_TAPS)
    ) u_store (
        .clk          (clk),
        .ctl          (store_ctl),
        .wr_grid_addr (ga_x[GRID_AW-1:0]),
        .wr_re        (sample_re),
        .wr_im        (sample_im),
        .wr_sw_addr   (tap_x[TAP_W-1:0]),
        .wr_pf_addr   (pf_wr_x[PF_W-1:0]),
        .wr_weight    (weight),
        .rd_grid_addr (grid_raddr),
        .rd_sw_addr   (sw_raddr),
        .rd_pf_addr   (pf_raddr),
        .grid_re_q    (grid_re_q),
        .grid_im_q    (grid_im_q),
        .sw_q         (sw_q),
        .pf_q         (pf_q)
    );

    // ------------------------------------------------------------------------
    // coordinate wrap
    // ------------------------------------------------------------------------
    assign mod_coord = mod_sel_row ? coord_second_reg : coord_first_reg;
    // coordinate - half width + side/2, start of the tap walk
    assign mod_val   = {{(VAL_W-COORD_W){mod_coord[COORD_W-1]}}, mod_coord}
                     - VAL_W'(hw_eff) + VAL_W'(side_eff >> 1);
    assign mod_abs   = mod_val[VAL_W-1] ? (VAL_W'(0) - mod_val) : mod_val;

    ggi_mod_unit #(
        .SIDE_W (SIDE_W)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .mag    (mod_abs[MAG_W-1:0]),
        .neg    (mod_val[VAL_W-1]),
        .side   (side_eff),
        .done   (mod_done),
        .result (mod_result)
    );

    // ------------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RD1:
            begin
                mul_a = WT_W'(row_cur_reg);
                mul_b = (WT_W+1)'(side_eff);
            end
            S_MW1:
            begin
                mul_a = sw1_reg;
                mul_b = {1'b0, sw_q};
            end
            S_MW2:
            begin
                mul_a = pf1_reg;
                mul_b = {1'b0, pf_q};
            end
            S_MAMP:
            begin
                mul_a = amp_reg;
                mul_b = {1'b0, rnd};
            end
            S_MU:
            begin
                mul_a = rnd;
                mul_b = {1'b0, t2v_reg};
            end
            S_MQ:
            begin
                mul_a = rnd;
                mul_b = (WT_W+1)'(grid_re_q);
            end
            S_MIM:
            begin
                mul_a = qv_reg;
                mul_b = (WT_W+1)'(grid_im_q);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ggi_mul_unit u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .prod    (prod),
        .rnd     (rnd),
        .rnd_sat (rnd_sat)
    );

    assign acc_re_add = acc_add(acc_re_reg, prod);
    assign acc_im_add = acc_add(acc_im_reg, prod);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        t1_next           = t1_reg;
        t2_next           = t2_reg;
        col_cur_next      = col_cur_reg;
        row0_next         = row0_reg;
        row_cur_next      = row_cur_reg;
        coord_first_next  = coord_first_reg;
        coord_second_next = coord_second_reg;
        amp_next          = amp_reg;
        sw1_next          = sw1_reg;
        pf1_next          = pf1_reg;
        t2v_next          = t2v_reg;
        qv_next           = qv_reg;
        acc_re_next       = acc_re_reg;
        acc_im_next       = acc_im_reg;
        sat_next          = sat_reg;
        sum_re_next       = sum_re_reg;
        sum_im_next       = sum_im_reg;
        saturated_next    = saturated_reg;
        mod_start         = 1'b0;
        mod_sel_row       = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && mode == MODE_EVAL)
                begin
                    coord_first_next  = coord_first;
                    coord_second_next = coord_second;
                    amp_next          = amplitude;
                    state_next        = S_COL;
                end
            end
            S_COL:
            begin
                mod_start  = 1'b1;
                state_next = S_COLW;
            end
            S_COLW:
            begin
                if (mod_done)
                begin
                    col_cur_next = mod_result;
                    mod_start    = 1'b1;
                    mod_sel_row  = 1'b1;
                    state_next   = S_ROWW;
                end
            end
            S_ROWW:
            begin
                mod_sel_row = 1'b1;
                if (mod_done)
                begin
                    row0_next    = mod_result;
                    row_cur_next = mod_result;
                    t1_next      = '0;
                    t2_next      = '0;
                    acc_re_next  = '0;
                    acc_im_next  = '0;
                    sat_next     = 1'b0;
                    state_next   = S_RD1;
                end
            end
            S_RD1:
                state_next = S_RD2;
            S_RD2:
            begin
                sw1_next   = sw_q;
                pf1_next   = pf_q;
                state_next = S_MW1;
            end
            S_MW1:
                state_next = S_MW2;
            S_MW2:
                state_next = S_MAMP;
            S_MAMP:
            begin
                sat_next   = sat_reg | rnd_sat;
                state_next = S_MT2;
            end
            S_MT2:
            begin
                t2v_next   = rnd;
                sat_next   = sat_reg | rnd_sat;
                state_next = S_MU;
            end
            S_MU:
            begin
                sat_next   = sat_reg | rnd_sat;
                state_next = S_MWAIT;
            end
            S_MWAIT:
                state_next = S_MQ;
            S_MQ:
            begin
                qv_next    = rnd;
                sat_next   = sat_reg | rnd_sat;
                state_next = S_MIM;
            end
            S_MIM:
            begin
                acc_re_next = acc_re_add[ACC_W-1:0];
                sat_next    = sat_reg | acc_re_add[ACC_W];
                state_next  = S_ACCIM;
            end
            S_ACCIM:
            begin
                if (complex_reg)
                begin
                    acc_im_next = acc_im_add[ACC_W-1:0];
                    sat_next    = sat_reg | acc_im_add[ACC_W];
                end
                // inner walk along the row coordinate, outer along the column
                if (t2_reg == span)
                begin
                    t2_next      = '0;
                    row_cur_next = row0_reg;
                    if (t1_reg == span)
                        state_next = S_DONE;
                    else
                    begin
                        t1_next      = t1_reg + 1'b1;
                        col_cur_next = (col_cur_reg + 1'b1 == side_eff) ?
                                       '0 : col_cur_reg + 1'b1;
                        state_next   = S_RD1;
                    end
                end
                else
                begin
                    t2_next      = t2_reg + 1'b1;
                    row_cur_next = (row_cur_reg + 1'b1 == side_eff) ?
                                   '0 : row_cur_reg + 1'b1;
                    state_next   = S_RD1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    sum_re_next    = acc_re_reg;
                    sum_im_next    = acc_im_reg;
                    saturated_next = sat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            t1_reg        <= '0;
            t2_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_cur_reg      <= col_cur_next;
        row0_reg         <= row0_next;
        row_cur_reg      <= row_cur_next;
        coord_first_reg  <= coord_first_next;
        coord_second_reg <= coord_second_next;
        amp_reg          <= amp_next;
        sw1_reg          <= sw1_next;
        pf1_reg          <= pf1_next;
        t2v_reg          <= t2v_next;
        qv_reg           <= qv_next;
        acc_re_reg       <= acc_re_next;
        acc_im_reg       <= acc_im_next;
        sat_reg          <= sat_next;
        sum_re_reg       <= sum_re_next;
        sum_im_reg       <= sum_im_next;
        saturated_reg    <= saturated_next;
    end

    assign out_valid = out_valid_reg;
    assign sum_re    = sum_re_reg;
    assign sum_im    = sum_im_reg;
    assign saturated = saturated_reg;

`ifndef SYNTH
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result transfer offered without a finished evaluation");

    a_grid_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD2) |-> (32'(grid_raddr) < 32'(GRID_DEPTH)))
        else $error("grid read address beyond the store");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD1) |-> (col_cur_reg < side_eff && row_cur_reg < side_eff
                                  && t1_reg <= span && t2_reg <= span))
        else $error("tap walk left the grid or the tap range");

    a_wrap_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_COLW || state_reg == S_ROWW))
        else $error("coordinate wrap finished outside its wait state");
`endif

endmodule

/* tb/gaussian_grid_interpolator_core_tb.sv */
// ----------------------------------------------------------------------------
// gaussian_grid_interpolator_core_tb
// Self-checking bench for the gaussian grid interpolator core. Loads the
// weight tables and grid, then runs directed corners, register sweeps and
// random traffic. Every evaluation is predicted from a shadow copy of the
// grid, tables and registers and compared field by field with the block's
// result. Both handshake sides insert random idle cycles.
// ----------------------------------------------------------------------------
module gaussian_grid_interpolator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ggi_pkg::*;

    localparam int          GRID_DEPTH     = DEF_GRID_SIDE * DEF_GRID_SIDE;
    localparam int          TAPS           = DEF_MAX_TAPS;
    localparam int          HW_LIMIT       = (DEF_MAX_TAPS - 1) / 2;
    localparam int          ITEM_GOAL      = 1850;
    localparam int          SETTLE_CYCLES  = 32;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] Q_ONE          = 32'h0100_0000;
    localparam longint      ACC_HI         = (longint'(1) <<< 47) - 1;
    localparam longint      ACC_LO         = -ACC_HI - 1;

    typedef struct {
        logic [1:0]                 mode;
        logic [15:0]                addr;
        logic signed [SAMPLE_W-1:0] s_re;
        logic signed [SAMPLE_W-1:0] s_im;
        logic [TAP_CNT_W-1:0]       tap;
        logic                       ax;
        logic [WT_W-1:0]            wt;
        logic signed [COORD_W-1:0]  cf;
        logic signed [COORD_W-1:0]  cs;
        logic [WT_W-1:0]            amp;
    } grid_item_t;

    typedef struct {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
        logic                    sat;
    } interp_sum_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 mode;
    logic [15:0]                grid_address;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic [TAP_CNT_W-1:0]       tap_index;
    logic                       axis;
    logic [WT_W-1:0]            weight;
    logic signed [COORD_W-1:0]  coord_first;
    logic signed [COORD_W-1:0]  coord_second;
    logic [WT_W-1:0]            amplitude;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [ACC_W-1:0]    sum_re;
    logic signed [ACC_W-1:0]    sum_im;
    logic                       saturated;

    // shadow of the block's stores and registers
    logic signed [SAMPLE_W-1:0] grid_re_m [GRID_DEPTH];
    logic signed [SAMPLE_W-1:0] grid_im_m [GRID_DEPTH];
    bit                         grid_known [GRID_DEPTH];
    logic [WT_W-1:0]            sq_weight [TAPS];
    logic [WT_W-1:0]            pt_factor [2*TAPS];
    logic [8:0]                 side_reg;
    logic [HW_W-1:0]            hw_reg;
    logic                       cplx_reg;

    interp_sum_t                pending_sums [$];
    int                         mismatches;
    int                         sent_items;
    int                         quiet_cycles;
    bit                         no_idle;

    gaussian_grid_interpolator_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .grid_address (grid_address),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .tap_index    (tap_index),
        .axis         (axis),
        .weight       (weight),
        .coord_first  (coord_first),
        .coord_second (coord_second),
        .amplitude    (amplitude),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sum_re       (sum_re),
        .sum_im       (sum_im),
        .saturated    (saturated)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int wrap_to(input int v, input int s);
        int r;
        r = v % s;
        if (r < 0)
            r += s;
        return r;
    endfunction

    function automatic int eff_side();
        int s;
        s = side_reg;
        if (s < 1)
            s = 1;
        if (s > DEF_GRID_SIDE)
            s = DEF_GRID_SIDE;
        return s;
    endfunction

    function automatic int eff_hw();
        return (hw_reg > HW_LIMIT) ? HW_LIMIT : int'(hw_reg);
    endfunction

    function automatic logic [WT_W-1:0] q824_mul(input logic [WT_W-1:0] a,
                                                 input logic [WT_W-1:0] b,
                                                 inout bit sat);
        logic [63:0] p;
        p = ({32'd0, a} * {32'd0, b} + 64'd8388608) >> 24;
        if (p > 64'hFFFF_FFFF)
        begin
            sat = 1'b1;
            return '1;
        end
        return p[31:0];
    endfunction

    function automatic longint acc_add(input longint acc, input logic [WT_W-1:0] q,
                                       input logic signed [SAMPLE_W-1:0] smp,
                                       inout bit sat);
        longint p;
        longint r;
        p = longint'({32'd0, q}) * longint'(smp);
        // round to nearest, ties toward plus infinity
        r = acc + ((p + 64'sd32768) >>> 16);
        if (r > ACC_HI)
        begin
            r = ACC_HI;
            sat = 1'b1;
        end
        if (r < ACC_LO)
        begin
            r = ACC_LO;
            sat = 1'b1;
        end
        return r;
    endfunction

    function automatic interp_sum_t interp_point(input logic signed [COORD_W-1:0] cf,
                                                 input logic signed [COORD_W-1:0] cs,
                                                 input logic [WT_W-1:0] amp);
        int          s;
        int          h;
        int          off;
        int          idx;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] q;
        longint      acc_re;
        longint      acc_im;
        bit          sat;
        interp_sum_t r;
        s = eff_side();
        h = eff_hw();
        off = s / 2;
        acc_re = 0;
        acc_im = 0;
        sat = 1'b0;
        for (int k1 = -h; k1 <= h; k1++)
        begin
            for (int k2 = -h; k2 <= h; k2++)
            begin
                idx = wrap_to(int'(cs) + k2 + off, s) * s + wrap_to(int'(cf) + k1 + off, s);
                t1 = q824_mul(sq_weight[k1+h], sq_weight[k2+h], sat);
                t2 = q824_mul(pt_factor[k1+h], pt_factor[TAPS+k2+h], sat);
                q = q824_mul(amp, t1, sat);
                q = q824_mul(q, t2, sat);
                acc_re = acc_add(acc_re, q, grid_re_m[idx], sat);
                if (cplx_reg)
                    acc_im = acc_add(acc_im, q, grid_im_m[idx], sat);
            end
        end
        r.re = acc_re[ACC_W-1:0];
        r.im = acc_im[ACC_W-1:0];
        r.sat = sat;
        return r;
    endfunction

    // update the shadow for one accepted transfer
    function automatic void apply_item(input grid_item_t it);
        case (it.mode)
            MODE_GRID:
            begin
                grid_re_m[it.addr] = it.s_re;
                grid_im_m[it.addr] = it.s_im;
                grid_known[it.addr] = 1'b1;
                sent_items++;
            end
            MODE_SQW:
            begin
                if (it.tap < TAPS)
                begin
                    sq_weight[it.tap] = it.wt;
                    sent_items++;
                end
            end
            MODE_PF:
            begin
                if (it.tap < TAPS)
                begin
                    pt_factor[(it.ax ? TAPS : 0) + it.tap] = it.wt;
                    sent_items++;
                end
            end
            default:
            begin
                pending_sums.push_back(interp_point(it.cf, it.cs, it.amp));
                sent_items++;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] draw_q824();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 4)
            return $urandom;
        if (r < 7)
            return $urandom_range(0, 32'h00FF_FFFF);
        return $urandom_range(32'h00C0_0000, 32'h0140_0000);
    endfunction

    function automatic grid_item_t random_item();
        grid_item_t it;
        it.mode = MODE_GRID;
        it.addr = $urandom_range(0, 65535);
        it.s_re = SAMPLE_W'($urandom);
        it.s_im = SAMPLE_W'($urandom);
        it.tap = TAP_CNT_W'($urandom_range(0, 15));
        it.ax = 1'($urandom_range(0, 1));
        it.wt = $urandom;
        it.cf = COORD_W'($urandom);
        it.cs = COORD_W'($urandom);
        it.amp = $urandom;
        return it;
    endfunction

    // random coordinate whose wrapped position lands on target
    function automatic int aim_coord(input int target);
        int s;
        int c;
        s = eff_side();
        c = int'($urandom_range(0, 65535)) - 32768;
        c = c + target - wrap_to(c + s / 2, s);
        if (c > 32767)
            c -= s;
        if (c < -32768)
            c += s;
        return c;
    endfunction

    // small grids are fully loaded; large ones use a few hot spots
    task automatic pick_target(output int row, output int col);
        int s;
        int h;
        s = eff_side();
        if (s <= 16)
        begin
            row = $urandom_range(0, s - 1);
            col = $urandom_range(0, s - 1);
        end
        else
        begin
            h = $urandom_range(0, 2);
            row = (h == 0) ? 0 : (h == 1) ? s - 1 : 3 * s / 4;
            col = (h == 0) ? 0 : (h == 1) ? s / 2 : s - 1;
            row = (row + $urandom_range(0, 1)) % s;
            col = (col + $urandom_range(0, 1)) % s;
        end
    endtask

    task automatic send_item(input grid_item_t it);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= it.mode;
        grid_address <= it.addr;
        sample_re    <= it.s_re;
        sample_im    <= it.s_im;
        tap_index    <= it.tap;
        axis         <= it.ax;
        weight       <= it.wt;
        coord_first  <= it.cf;
        coord_second <= it.cs;
        amplitude    <= it.amp;
        do @(posedge clk); while (in_stall !== 1'b0);
        apply_item(it);
    endtask

    task automatic send_table_write(input logic [1:0] m, input logic ax, input int tap,
                                    input logic [31:0] wt);
        grid_item_t it;
        it = random_item();
        it.mode = m;
        it.ax = ax;
        it.tap = TAP_CNT_W'(tap);
        it.wt = wt;
        send_item(it);
    endtask

    task automatic send_grid_write(input int addr, input int s_re, input int s_im);
        grid_item_t it;
        it = random_item();
        it.addr = addr[15:0];
        it.s_re = SAMPLE_W'(s_re);
        it.s_im = SAMPLE_W'(s_im);
        send_item(it);
    endtask

    // load every grid entry the window reads that is not yet known, then evaluate
    task automatic eval_at(input int cf, input int cs, input logic [31:0] amp);
        int         s;
        int         h;
        int         idx;
        grid_item_t it;
        s = eff_side();
        h = eff_hw();
        for (int k1 = -h; k1 <= h; k1++)
        begin
            for (int k2 = -h; k2 <= h; k2++)
            begin
                idx = wrap_to(cs + k2 + s / 2, s) * s + wrap_to(cf + k1 + s / 2, s);
                if (!grid_known[idx])
                begin
                    it = random_item();
                    it.addr = idx[15:0];
                    send_item(it);
                end
            end
        end
        it = random_item();
        it.mode = MODE_EVAL;
        it.cf = cf[15:0];
        it.cs = cs[15:0];
        it.amp = amp;
        send_item(it);
    endtask

    task automatic eval_near(input int row, input int col, input logic [31:0] amp);
        int cf;
        int cs;
        cf = aim_coord(col);
        cs = aim_coord(row);
        eval_at(cf, cs, amp);
    endtask

    task automatic eval_anywhere();
        int row;
        int col;
        pick_target(row, col);
        eval_near(row, col, draw_q824());
    endtask

    // wait until the block is idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_GRID_SIDE:  side_reg = val[8:0];
            REG_HALF_WIDTH: hw_reg = val[HW_W-1:0];
            REG_COMPLEX:    cplx_reg = val[0];
            default:        ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int side, input int hw, input bit cplx);
        settle();
        write_reg(REG_GRID_SIDE, side);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_COMPLEX, cplx);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string what, input longint e,
                                          input longint a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, e, a);
    endfunction

    task automatic check_result();
        interp_sum_t e;
        if (pending_sums.size() == 0)
        begin
            note_mismatch("result with nothing pending, sum_re", 0, sum_re);
            return;
        end
        e = pending_sums.pop_front();
        if (sum_re !== e.re)
            note_mismatch("sum_re", e.re, sum_re);
        if (sum_im !== e.im)
            note_mismatch("sum_im", e.im, sum_im);
        if (saturated !== e.sat)
            note_mismatch("saturated", e.sat, saturated);
    endtask

    initial
    begin : result_sink
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait();
            if (hold != 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                do @(posedge clk); while (out_valid !== 1'b1);
                repeat (hold - 1) @(posedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
            check_result();
        end
    end

    // ends the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_load_tables();
        for (int t = 0; t < TAPS; t++)
            send_table_write(MODE_SQW, 1'b0, t, $urandom_range(32'h00C0_0000, 32'h0140_0000));
        for (int a = 0; a < 2; a++)
        begin
            for (int t = 0; t < TAPS; t++)
                send_table_write(MODE_PF, a[0], t,
                                 $urandom_range(32'h00C0_0000, 32'h0140_0000));
        end
        // covers every entry of any grid up to 16 by 16
        for (int a = 0; a < 256; a++)
            send_grid_write(a, $urandom, $urandom);
    endtask

    task automatic test_directed();
        // sample extremes, last address and the window centre of coordinate zero
        send_grid_write(65535, -8388608, 8388607);
        send_grid_write(128 * 256 + 128, 8388607, -8388608);
        eval_at(0, 0, Q_ONE);
        // tap index past the table is dropped
        send_table_write(MODE_SQW, 1'b0, 15, 32'hFFFF_FFFF);
        send_table_write(MODE_PF, 1'b1, 15, 32'h0);
        send_table_write(MODE_PF, 1'b0, 15, 32'hFFFF_FFFF);
        eval_at(0, 0, 32'hFFFF_FFFF);
        eval_at(0, 0, 32'h0);
        // weight extremes, then set both entries to one
        send_table_write(MODE_SQW, 1'b0, 3, 32'hFFFF_FFFF);
        send_table_write(MODE_PF, 1'b1, 0, 32'h0);
        eval_at(0, 0, Q_ONE);
        send_table_write(MODE_SQW, 1'b0, 3, Q_ONE);
        send_table_write(MODE_PF, 1'b1, 0, Q_ONE);
        // coordinate extremes and the wrap at the far corner
        eval_at(-32768, 32767, Q_ONE);
        eval_at(32767, -32768, Q_ONE);
        eval_near(255, 255, Q_ONE);
    endtask

    task automatic test_config_corners();
        int sides [9] = '{0, 1, 2, 16, 257, 511, 37, 256, 100};
        int hws [9]   = '{0, 7, 1, 2, 3, 6, 4, 0, 5};
        bit cpx [9]   = '{1, 0, 1, 0, 1, 1, 0, 1, 1};
        for (int i = 0; i < 9; i++)
        begin
            set_config(sides[i], hws[i], cpx[i]);
            eval_anywhere();
            eval_anywhere();
        end
    endtask

    task automatic test_pause_and_resume();
        set_config(256, 2, 1'b1);
        no_idle = 1'b1;
        repeat (4) eval_near(0, 0, draw_q824());
        // hold off until the last result is out
        settle();
        repeat (4) eval_near(0, 0, draw_q824());
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int         big_sides [7] = '{0, 37, 100, 255, 256, 257, 511};
        int         side;
        int         hw;
        int         sel;
        grid_item_t it;
        while (sent_items < ITEM_GOAL)
        begin
            if ($urandom_range(0, 9) < 5)
                side = $urandom_range(1, 16);
            else
                side = big_sides[$urandom_range(0, 6)];
            sel = $urandom_range(0, 19);
            hw = (sel < 14) ? $urandom_range(0, 3) : (sel < 19) ? $urandom_range(4, 6) : 7;
            set_config(side, hw, 1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int step = 0; step < 120 && sent_items < ITEM_GOAL; step++)
            begin
                sel = $urandom_range(0, 99);
                it = random_item();
                if (sel < 40)
                    eval_anywhere();
                else if (sel < 60)
                    send_item(it);
                else if (sel < 75)
                    send_table_write(MODE_SQW, it.ax, $urandom_range(0, 14), draw_q824());
                else if (sel < 90)
                    send_table_write(MODE_PF, it.ax, $urandom_range(0, 14), draw_q824());
                else
                begin
                    // any tap and any weight, including the dropped index
                    it.mode = $urandom_range(0, 1) ? MODE_SQW : MODE_PF;
                    send_item(it);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        mode         = MODE_GRID;
        grid_address = '0;
        sample_re    = '0;
        sample_im    = '0;
        tap_index    = '0;
        axis         = 1'b0;
        weight       = '0;
        coord_first  = '0;
        coord_second = '0;
        amplitude    = '0;
        side_reg     = RST_GRID_SIDE;
        hw_reg       = RST_HALF_WIDTH;
        cplx_reg     = RST_COMPLEX;
        mismatches   = 0;
        sent_items   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_load_tables();
        test_directed();
        test_config_corners();
        test_pause_and_resume();
        test_random_traffic();
        settle();

        if (mismatches == 0 && pending_sums.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
